@@ src/sawtc_pkg.sv @@
// ----------------------------------------------------------------------------
// sawtc_pkg: shared types and constants
// Cache geometry, operation and result codes, result record, LFSR constants.
// ----------------------------------------------------------------------------
package sawtc_pkg;

  // cache geometry
  localparam int NUM_SETS   = 128;
  localparam int NUM_WAYS   = 8;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS  = 27;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_READ_DONE  = 2'd0,
    KIND_WRITE_DONE = 2'd1,
    KIND_FILL_REQ   = 2'd2,
    KIND_FILL_ACK   = 2'd3
  } kind_t;

  localparam int LINE_OUT_BITS = 21;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] SEED_RESET = 16'd44257;

  typedef struct packed {
    kind_t                     kind;
    logic                      hit;
    logic [31:0]               read_data;
    logic [LINE_OUT_BITS-1:0]  line_address;
    logic                      last;
  } result_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

@@ src/sawtc_out_fifo.sv @@
// ----------------------------------------------------------------------------
// sawtc_out_fifo: result queue
// Small queue of result records in front of the output stream.
// ----------------------------------------------------------------------------
module sawtc_out_fifo
  import sawtc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space3,
  output logic    empty,
  input  logic    pop,
  output result_t head
);
  result_t     q [4];
  logic [1:0]  wp;
  logic [1:0]  rp;
  logic [2:0]  cnt;

  assign empty  = (cnt == 3'd0);
  assign space3 = (cnt <= 3'd1);
  assign head   = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, push} - {2'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (cnt != 3'd4)) else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("result queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'd4) else $error("result count out of range");
endmodule

@@ src/set_assoc_write_through_cache_top.sv @@
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache_top: write-through, no-write-allocate cache
// Set-associative cache with random replacement and eight-word line fills.
// ----------------------------------------------------------------------------
// A request is a read, a write or one word of a line fill, selected by the
// operation code on s_tuser; requests are handled one at a time. A read or
// write within one line passes through the idle state, one tag lookup (tag
// and valid memories, registered read), two data memory steps for the two
// words the bytes may span, and one result step. A line crossing adds a
// second tag lookup, and each fill request a read emits adds a result step.
// Fill words pass through idle, a tag lookup for the victim choice and a
// data write; an unused operation code is taken in idle and goes no further.
// After reset a clearing pass sweeps the valid bits of all NUM_SETS sets,
// during which no request is taken. Results go through a four-entry queue;
// a request is taken only while at least three entries are free, so a
// stalled result side holds up the input once more than one result waits.
module set_assoc_write_through_cache_top
  import sawtc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // address, size, write_data, fill_word, fill_index, pad (7 bits)
  input  logic [135:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, read_data, line_address, pad (2 bits)
  output logic [55:0]  m_tdata,
  // kind[1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int OFF_BITS  = $clog2(LINE_BYTES);
  localparam int WORDS     = LINE_BYTES / 8;
  localparam int WIDX_BITS = $clog2(WORDS);
  localparam int LINE_BITS = ADDR_BITS - OFF_BITS;
  localparam int TAG_BITS  = LINE_BITS - SET_BITS;
  localparam int TAGW      = NUM_WAYS * TAG_BITS;
  localparam int DA_BITS   = SET_BITS + WAY_BITS + WIDX_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_TAG, S_DATA, S_DATA2, S_EMIT, S_FILL
  } state_t;

  // ---- input fields
  logic [1:0]           in_op;
  logic [ADDR_BITS-1:0] in_addr;
  logic [2:0]           in_size;
  logic [31:0]          in_wdata;
  logic [63:0]          in_fword;
  logic [2:0]           in_fidx;
  assign in_op    = s_tuser;
  assign in_addr  = s_tdata[0 +: ADDR_BITS];
  assign in_size  = s_tdata[27 +: 3];
  assign in_wdata = s_tdata[30 +: 32];
  assign in_fword = s_tdata[62 +: 64];
  assign in_fidx  = s_tdata[126 +: 3];

  // ---- memories: tags per set (all ways in one row), data words
  logic [TAGW-1:0]     tag_mem [NUM_SETS];
  logic [63:0]         data_mem [NUM_SETS*NUM_WAYS*WORDS];
  logic [NUM_WAYS-1:0] valid_mem [NUM_SETS];
  logic [TAGW-1:0]     tag_rd;
  logic [NUM_WAYS-1:0] valid_rd;
  logic [63:0]         data_rd;
  logic                tag_we, valid_we, data_we;
  logic [SET_BITS-1:0] tag_ra, tag_wa, valid_wa;
  logic [TAGW-1:0]     tag_wd;
  logic [NUM_WAYS-1:0] valid_wd;
  logic [DA_BITS-1:0]  data_ra, data_wa;
  logic [63:0]         data_wd;

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (valid_we) valid_mem[valid_wa] <= valid_wd;
    tag_rd   <= tag_mem[tag_ra];
    valid_rd <= valid_mem[tag_ra];
  end
  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_wa] <= data_wd;
    data_rd <= data_mem[data_ra];
  end

  // ---- request registers
  state_t               state;
  logic [1:0]           op;
  logic [ADDR_BITS-1:0] addr;
  logic [2:0]           sz;
  logic [31:0]          wdata;
  logic [63:0]          fword;
  logic [2:0]           fidx;
  logic                 second;   // doing the second line
  logic                 hit_a, hit_b;
  logic [WAY_BITS-1:0]  way_a, way_b;
  logic [63:0]          word_a;
  logic [SET_BITS-1:0]  clr_set;
  logic [15:0]          lfsr;
  logic [WAY_BITS-1:0]  fill_way;

  logic [2:0]           sz_eff;
  logic [ADDR_BITS-1:0] addr_end;
  logic [LINE_BITS-1:0] line_a, line_b, line_cur;
  assign sz_eff   = (sz == 3'd0) ? 3'd1 : ((sz > 3'd4) ? 3'd4 : sz);
  assign addr_end = addr + ADDR_BITS'(sz_eff - 3'd1);
  assign line_a   = addr[ADDR_BITS-1:OFF_BITS];
  assign line_b   = addr_end[ADDR_BITS-1:OFF_BITS];
  assign line_cur = second ? line_b : line_a;

  // lookup on the registered row
  logic [NUM_WAYS-1:0] match;
  logic                lk_hit;
  logic [WAY_BITS-1:0] lk_way, inv_way;
  logic                has_inv;
  always_comb begin
    lk_hit  = 1'b0;
    lk_way  = '0;
    has_inv = 1'b0;
    inv_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      match[w] = valid_rd[w] &&
                 tag_rd[w*TAG_BITS +: TAG_BITS] == line_cur[LINE_BITS-1:SET_BITS];
      if (match[w]) begin
        lk_hit = 1'b1;
        lk_way = WAY_BITS'(w);
      end
      if (!valid_rd[w]) begin
        has_inv = 1'b1;
        inv_way = WAY_BITS'(w);
      end
    end
  end

  // byte offset within the first touched word
  logic [2:0]  boff;
  assign boff = addr[2:0];

  // address of the second touched word (may be line b)
  logic [ADDR_BITS-1:0] addr_w2;
  assign addr_w2 = {addr[ADDR_BITS-1:3] + (ADDR_BITS-3)'(1), 3'b000};

  function automatic logic [DA_BITS-1:0] daddr(input logic [ADDR_BITS-1:0] a,
                                               input logic [WAY_BITS-1:0] w);
    return {a[OFF_BITS +: SET_BITS], w, a[3 +: WIDX_BITS]};
  endfunction

  // read assembly and write merge
  logic [127:0] pair;
  logic [31:0]  rdata;
  logic [31:0]  smask;
  logic [127:0] wpair, wmask;
  always_comb begin
    pair  = {data_rd, word_a};
    rdata = 32'(pair >> {boff, 3'b000});
    unique case (sz_eff)
      3'd1:    smask = 32'h0000_00FF;
      3'd2:    smask = 32'h0000_FFFF;
      3'd3:    smask = 32'h00FF_FFFF;
      default: smask = 32'hFFFF_FFFF;
    endcase
    rdata = rdata & smask;
    wpair = {96'b0, wdata & smask} << {boff, 3'b000};
    wmask = {96'b0, smask} << {boff, 3'b000};
  end

  // result queue
  result_t res;
  logic    push, space3, q_empty, pop;
  result_t head;
  sawtc_out_fifo u_fifo (
    .clk, .rst, .push, .push_data(res), .space3, .empty(q_empty), .pop, .head
  );
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = !q_empty;
  assign m_tdata  = {2'b0, head.line_address, head.read_data, head.hit};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  // pending fill requests for the read
  logic       req_a, req_b;
  logic [1:0] emit_step;
  logic       hit_all;
  assign hit_all = hit_a && hit_b;

  assign s_tready = (state == S_IDLE) && space3;

  always_comb begin
    // first lookup cycle of a read or write already fetches line b's row
    tag_ra   = s_tready ? in_addr[OFF_BITS +: SET_BITS] :
               ((state == S_TAG && op != OP_FILL) ? line_b[SET_BITS-1:0] :
                                                    line_a[SET_BITS-1:0]);
    tag_we   = 1'b0;
    tag_wa   = addr[OFF_BITS +: SET_BITS];
    tag_wd   = tag_rd;
    valid_we = (state == S_CLEAR);
    valid_wa = (state == S_CLEAR) ? clr_set : addr[OFF_BITS +: SET_BITS];
    valid_wd = '0;
    data_we  = 1'b0;
    data_wa  = daddr(addr, way_a);
    data_wd  = data_rd;
    data_ra  = daddr(addr, lk_way);
    push     = 1'b0;
    res      = '0;
    if (state == S_TAG && second) begin
      data_ra = daddr(addr, way_a);
    end
    if (state == S_DATA && op == OP_WRITE && hit_a) begin
      data_we = 1'b1;
      data_wa = daddr(addr, way_a);
      data_wd = (data_rd & ~wmask[63:0]) | wpair[63:0];
    end
    if (state == S_DATA2 && op == OP_WRITE && hit_b) begin
      data_we = 1'b1;
      data_wa = daddr(addr_w2, way_b);
      data_wd = (data_rd & ~wmask[127:64]) | wpair[127:64];
    end
    // second word is read in S_DATA and held until the results are out
    if (state == S_DATA || state == S_DATA2 || state == S_EMIT) begin
      data_ra = daddr(addr_w2, way_b);
    end
    if (state == S_EMIT) begin
      push = 1'b1;
      if (op == OP_WRITE) begin
        res.kind = KIND_WRITE_DONE;
        res.hit  = hit_all;
        res.last = 1'b1;
      end else if (emit_step == 2'd0 && req_a) begin
        res.kind = KIND_FILL_REQ;
        res.line_address = LINE_OUT_BITS'(line_a);
      end else if (req_b && emit_step == {1'b0, req_a}) begin
        res.kind = KIND_FILL_REQ;
        res.line_address = LINE_OUT_BITS'(line_b);
      end else begin
        res.kind = KIND_READ_DONE;
        res.hit  = hit_all;
        res.read_data = hit_all ? rdata : 32'd0;
        res.last = 1'b1;
      end
    end
    if (state == S_FILL) begin
      data_we = 1'b1;   // every fill index lies within the line
      data_wa = {addr[OFF_BITS +: SET_BITS], fill_way, fidx[WIDX_BITS-1:0]};
      data_wd = fword;
      valid_we = 1'b1;
      valid_wd = valid_rd;
      valid_wd[fill_way] = (fidx == 3'd7);
      if (fidx == 3'd7) begin
        tag_we = 1'b1;
        tag_wd[fill_way*TAG_BITS +: TAG_BITS] = line_a[LINE_BITS-1:SET_BITS];
        push = 1'b1;
        res.kind = KIND_FILL_ACK;
        res.last = 1'b1;
      end else if (fidx != 3'd0) begin
        valid_we = 1'b0;
      end
    end
  end

  logic [WAY_BITS-1:0] fw_pick;
  logic [15:0]         lfsr_n;
  assign lfsr_n  = lfsr_step(lfsr);
  assign fw_pick = lk_hit ? lk_way : (has_inv ? inv_way : lfsr_n[WAY_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_set   <= '0;
      lfsr      <= SEED_RESET;
      fill_way  <= '0;
      second    <= 1'b0;
      emit_step <= '0;
    end else begin
      if (cfg_we) lfsr <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
      unique case (state)
        S_CLEAR: begin
          clr_set <= clr_set + SET_BITS'(1);
          if (clr_set == SET_BITS'(NUM_SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          second    <= 1'b0;
          emit_step <= '0;
          if (s_tvalid && s_tready) begin
            op <= in_op; addr <= in_addr; sz <= in_size; wdata <= in_wdata;
            fword <= in_fword; fidx <= in_fidx;
            if (in_op != OP_NONE) state <= S_TAG;
          end
        end
        S_TAG: begin
          if (op == OP_FILL) begin
            if (fidx == 3'd0) begin
              fill_way <= fw_pick;
              if (!lk_hit && !has_inv && !cfg_we) lfsr <= lfsr_n;
            end
            state <= S_FILL;
          end else if (!second) begin
            hit_a <= lk_hit; way_a <= lk_way;
            hit_b <= lk_hit; way_b <= lk_way;
            req_a <= !lk_hit; req_b <= 1'b0;
            if (line_b != line_a) second <= 1'b1;
            else state <= S_DATA;
          end else begin
            hit_b <= lk_hit; way_b <= lk_way; req_b <= !lk_hit;
            state <= S_DATA;
          end
        end
        S_DATA: begin
          word_a <= data_rd;
          state  <= S_DATA2;
        end
        S_DATA2: state <= S_EMIT;
        S_EMIT: begin
          emit_step <= emit_step + 2'd1;
          if (res.last) state <= S_IDLE;
        end
        S_FILL: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // first word is read at the end of the last tag cycle and captured as
  // word_a in S_DATA; the following word is read in S_DATA.

  // pending requests never exceed the queue's free room
  a_room: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> space3) else $error("accepted without room");
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == KIND_FILL_ACK) |-> res.last) else $error("ack not last");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready) else $error("accept during clear");
  a_lfsr_nz: assert property (@(posedge clk) disable iff (rst)
    lfsr != 16'd0) else $error("lfsr stuck at zero");
endmodule
